### sv/uvcfa_pkg.sv
`default_nettype none

package uvcfa_pkg;

   // Fixed field widths.
   localparam int CHUNK_W  = 10;
   localparam int FRAME_W  = 24;
   localparam int FILL_W   = 25;
   localparam int IVL_W    = 20;
   localparam int TIME_W   = 40;
   localparam int SEQ_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;

   // Smallest legal header length.
   localparam logic [7:0] MIN_HEADER = 8'd2;

   // Bits of the header info byte.
   localparam int INFO_FID_BIT = 0;
   localparam int INFO_EOF_BIT = 1;
   localparam int INFO_ERR_BIT = 6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BYTES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_HIGH = 2'd2;

   // Register values after reset.
   localparam logic [FRAME_W-1:0] FRAME_BYTES_RESET   = 24'd405000;
   localparam logic [IVL_W-1:0]   INTERVAL_LOW_RESET  = 20'd16666;
   localparam logic [IVL_W-1:0]   INTERVAL_HIGH_RESET = 20'd200000;

   // Result kinds.
   localparam logic KIND_WRITE   = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_bytes;
      logic [IVL_W-1:0]   interval_low;
      logic [IVL_W-1:0]   interval_high;
   } uvcfa_cfg_type;

   typedef struct packed {
      logic               fid_seen;
      logic               current_fid;
      logic               synced;
      logic               have_buffer;
      logic               last_end_valid;
      logic [FILL_W-1:0]  fill_offset;
      logic [SEQ_W-1:0]   seq_counter;
      logic [TIME_W-1:0]  last_end_time;
      logic [IVL_W-1:0]   smoothed;
   } uvcfa_frame_state_type;

   typedef struct packed {
      uvcfa_frame_state_type st;
      logic                  deliver;
      logic [SEQ_W-1:0]      seq;
   } uvcfa_end_type;

   typedef struct packed {
      logic               kind;
      logic [FRAME_W-1:0] write_offset;
      logic [7:0]         pixel_byte;
      logic               claimed_buffer;
      logic [SEQ_W-1:0]   frame_sequence;
      logic [TIME_W-1:0]  frame_time_us;
      logic [IVL_W-1:0]   avg_interval_us;
      logic               last;
   } uvcfa_result_type;

   typedef struct packed {
      logic [1:0]       count;
      uvcfa_result_type first;
      uvcfa_result_type second;
   } uvcfa_step_type;

   // Closes the current frame: updates the interval average, the sequence
   // counter and the buffer, and reports whether the frame goes out.
   function automatic uvcfa_end_type finish_frame(input uvcfa_frame_state_type st_i,
                                                  input logic [TIME_W-1:0] now,
                                                  input uvcfa_cfg_type cfg);
      uvcfa_end_type     r;
      logic [TIME_W-1:0] d;
      logic [IVL_W+2:0]  acc;
      logic              was_synced;
      r          = '0;
      r.st       = st_i;
      r.seq      = st_i.seq_counter;
      was_synced = st_i.synced;
      d          = now - st_i.last_end_time;
      acc        = {st_i.smoothed, 3'b000} - {3'b000, st_i.smoothed}
                   + {3'b000, d[IVL_W-1:0]};
      if (st_i.last_end_valid &&
          d >= {20'd0, cfg.interval_low} && d <= {20'd0, cfg.interval_high}) begin
         if (st_i.smoothed != '0) begin
            r.st.smoothed = acc[IVL_W+2:3];
         end else begin
            r.st.smoothed = d[IVL_W-1:0];
         end
      end
      r.st.last_end_time  = now;
      r.st.last_end_valid = 1'b1;
      r.st.synced         = 1'b1;
      if (!was_synced &&
          (!st_i.have_buffer || st_i.fill_offset != {1'b0, cfg.frame_bytes})) begin
         if (st_i.have_buffer) begin
            r.st.fill_offset = '0;
         end
      end else begin
         r.st.seq_counter = st_i.seq_counter + 32'd1;
         if (st_i.have_buffer) begin
            if (st_i.fill_offset != {1'b0, cfg.frame_bytes}) begin
               r.st.fill_offset = '0;
            end else begin
               r.deliver        = 1'b1;
               r.st.have_buffer = 1'b0;
               r.st.fill_offset = '0;
            end
         end
      end
      return r;
   endfunction

   function automatic uvcfa_result_type make_delivery(input logic [SEQ_W-1:0] seq,
                                                      input logic [TIME_W-1:0] now,
                                                      input logic [IVL_W-1:0] avg);
      uvcfa_result_type r;
      r                 = '0;
      r.kind            = KIND_DELIVER;
      r.frame_sequence  = seq;
      r.frame_time_us   = now;
      r.avg_interval_us = avg;
      return r;
   endfunction

   function automatic uvcfa_result_type make_write(input logic [FRAME_W-1:0] off,
                                                   input logic [7:0] data,
                                                   input logic claimed);
      uvcfa_result_type r;
      r                = '0;
      r.kind           = KIND_WRITE;
      r.write_offset   = off;
      r.pixel_byte     = data;
      r.claimed_buffer = claimed;
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/uvcfa_deframer.sv
`default_nettype none

// Packet header parsing and frame assembly state. Works out the full state
// update and up to two results for one byte combinationally.
module uvcfa_deframer #(
   parameter int PACKET_SPAN = 512
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step_en,
   input  wire logic [7:0]                   data_byte,
   input  wire logic [uvcfa_pkg::CHUNK_W-1:0] chunk_len,
   input  wire logic                         buffer_available,
   input  wire logic [uvcfa_pkg::TIME_W-1:0] time_us,
   input  wire uvcfa_pkg::uvcfa_cfg_type     cfg,
   output uvcfa_pkg::uvcfa_step_type         step
);

   localparam int POS_W = $clog2(PACKET_SPAN);
   localparam int CMP_W = ($clog2(PACKET_SPAN + 1) > uvcfa_pkg::CHUNK_W) ?
                          $clog2(PACKET_SPAN + 1) : uvcfa_pkg::CHUNK_W;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       hlen_ff, hlen_in;
   logic             skip_ff, skip_in;
   logic             err_ff, err_in;
   logic             eof_ff, eof_in;
   logic             drop_ff, drop_in;
   uvcfa_pkg::uvcfa_frame_state_type fs_ff, fs_in;

   uvcfa_pkg::uvcfa_end_type end_a, end_b;
   logic [CMP_W-1:0] clen;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] hlen_x;
   logic             pkt_end;
   logic             fid;
   logic             append_go;

   always_comb begin
      clen    = (CMP_W'(chunk_len) > CMP_W'(PACKET_SPAN)) ?
                CMP_W'(PACKET_SPAN) : CMP_W'(chunk_len);
      pos_x   = CMP_W'(pos_ff);
      hlen_x  = CMP_W'(hlen_ff);
      pkt_end = (pos_x + CMP_W'(1)) >= clen;
      fid     = data_byte[uvcfa_pkg::INFO_FID_BIT];

      pos_in    = pos_ff;
      hlen_in   = hlen_ff;
      skip_in   = skip_ff;
      err_in    = err_ff;
      eof_in    = eof_ff;
      drop_in   = drop_ff;
      fs_in     = fs_ff;
      end_a     = '0;
      end_b     = '0;
      append_go = 1'b0;
      step      = '0;

      if (pos_ff == '0) begin
         skip_in = (data_byte < uvcfa_pkg::MIN_HEADER) || (CMP_W'(data_byte) > clen);
         err_in  = 1'b0;
         eof_in  = 1'b0;
         drop_in = 1'b0;
         hlen_in = data_byte;
      end else if (!skip_ff) begin
         if (pos_ff == POS_W'(1)) begin
            eof_in = data_byte[uvcfa_pkg::INFO_EOF_BIT];
            if (fs_ff.fid_seen && fid != fs_ff.current_fid) begin
               end_a = uvcfa_pkg::finish_frame(fs_in, time_us, cfg);
               fs_in = end_a.st;
               if (end_a.deliver) begin
                  step.first = uvcfa_pkg::make_delivery(end_a.seq, time_us,
                                                        end_a.st.smoothed);
                  step.count = 2'd1;
               end
            end
            fs_in.current_fid = fid;
            fs_in.fid_seen    = 1'b1;
            if (data_byte[uvcfa_pkg::INFO_ERR_BIT]) begin
               err_in = 1'b1;
               if (fs_in.have_buffer) begin
                  fs_in.fill_offset = {1'b0, cfg.frame_bytes} + 25'd1;
               end
            end
         end else if (pos_x >= hlen_x && !err_ff && !drop_ff) begin
            // Payload byte: claim a buffer on the first byte if none is held.
            append_go = 1'b1;
            if (!fs_ff.have_buffer) begin
               if (pos_x == hlen_x && buffer_available) begin
                  fs_in.have_buffer = 1'b1;
                  fs_in.fill_offset = '0;
               end else begin
                  drop_in   = 1'b1;
                  append_go = 1'b0;
               end
            end
            if (append_go) begin
               if (fs_in.fill_offset >= {1'b0, cfg.frame_bytes}) begin
                  fs_in.fill_offset = {1'b0, cfg.frame_bytes} + 25'd1;
               end else begin
                  step.first = uvcfa_pkg::make_write(fs_in.fill_offset[23:0], data_byte,
                                                     !fs_ff.have_buffer);
                  step.count = 2'd1;
                  fs_in.fill_offset = fs_in.fill_offset + 25'd1;
               end
            end
         end
      end

      if (pkt_end) begin
         if (!skip_in && pos_ff != '0 && eof_in) begin
            end_b = uvcfa_pkg::finish_frame(fs_in, time_us, cfg);
            fs_in = end_b.st;
            if (end_b.deliver) begin
               if (step.count == 2'd0) begin
                  step.first = uvcfa_pkg::make_delivery(end_b.seq, time_us,
                                                        end_b.st.smoothed);
               end else begin
                  step.second = uvcfa_pkg::make_delivery(end_b.seq, time_us,
                                                         end_b.st.smoothed);
               end
               step.count = step.count + 2'd1;
            end
            fs_in.fid_seen = 1'b0;
         end
         pos_in = '0;
      end else begin
         pos_in = pos_ff + POS_W'(1);
      end

      if (step.count == 2'd1) begin
         step.first.last = 1'b1;
      end
      if (step.count == 2'd2) begin
         step.second.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         hlen_ff <= '0;
         skip_ff <= 1'b0;
         err_ff  <= 1'b0;
         eof_ff  <= 1'b0;
         drop_ff <= 1'b0;
         fs_ff   <= '0;
      end else if (step_en) begin
         pos_ff  <= pos_in;
         hlen_ff <= hlen_in;
         skip_ff <= skip_in;
         err_ff  <= err_in;
         eof_ff  <= eof_in;
         drop_ff <= drop_in;
         fs_ff   <= fs_in;
      end
   end

endmodule

`default_nettype wire

### sv/uvcfa_result_queue.sv
`default_nettype none

// Two-entry result buffer. It is loaded only when it will be empty after
// this cycle's pop, so a load always starts at slot zero.
module uvcfa_result_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire uvcfa_pkg::uvcfa_step_type  step,
   output logic                            can_load,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output uvcfa_pkg::uvcfa_result_type     out_result
);

   uvcfa_pkg::uvcfa_result_type slot_ff [2];
   uvcfa_pkg::uvcfa_result_type slot_in [2];
   logic       head_ff, head_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   always_comb begin
      out_valid  = count_ff != 2'd0;
      out_result = slot_ff[head_ff];
      pop        = out_valid && out_ready;
      can_load   = (count_ff == 2'd0) || (count_ff == 2'd1 && out_ready);

      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      head_in    = head_ff;
      count_in   = count_ff;
      if (load) begin
         slot_in[0] = step.first;
         slot_in[1] = step.second;
         head_in    = 1'b0;
         count_in   = step.count;
      end else if (pop) begin
         head_in  = ~head_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### sv/uvc_payload_frame_assembler.sv
// UVC payload frame assembler. Bytes of a camera bulk stream arrive one per
// req_ transfer, cut into packets of req_chunk_len bytes (at most PACKET_SPAN).
// Each packet's header (length byte, then info byte with FID, EOF and ERR) is
// stripped, and payload bytes come out as rsp_ write transfers at a running
// frame offset; a frame that holds exactly the configured byte count is
// announced by a delivery transfer carrying its sequence number, end time and
// a 7/8 moving average of the frame interval. rsp_last marks the final result
// of one input byte. Each byte is resolved in the cycle it is taken and its
// results are offered from the next cycle on, through a two-entry result
// buffer between the sides: with rsp_ready held high, a byte that yields zero
// or one result is taken every cycle, and a byte that yields two results (a
// payload write followed by an end-of-frame delivery) holds off the next byte
// while the buffer drains. Configuration is written through csr_, and the
// user must do so only while idle; the block has no check for this.
`default_nettype none

module uvc_payload_frame_assembler #(
   parameter int PACKET_SPAN = 512
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_data_byte,
   input  wire logic [uvcfa_pkg::CHUNK_W-1:0]   req_chunk_len,
   input  wire logic                            req_buffer_available,
   input  wire logic [uvcfa_pkg::TIME_W-1:0]    req_time_us,

   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_kind,
   output logic [uvcfa_pkg::FRAME_W-1:0]        rsp_write_offset,
   output logic [7:0]                           rsp_pixel_byte,
   output logic                                 rsp_claimed_buffer,
   output logic [uvcfa_pkg::SEQ_W-1:0]          rsp_frame_sequence,
   output logic [uvcfa_pkg::TIME_W-1:0]         rsp_frame_time_us,
   output logic [uvcfa_pkg::IVL_W-1:0]          rsp_avg_interval_us,
   output logic                                 rsp_last,

   input  wire logic                            csr_we,
   input  wire logic [uvcfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [uvcfa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   uvcfa_pkg::uvcfa_cfg_type    cfg_ff, cfg_in;
   uvcfa_pkg::uvcfa_step_type   step;
   uvcfa_pkg::uvcfa_result_type result;
   logic                        can_load;
   logic                        accept;

   // Configuration registers, each written whole on its index.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            uvcfa_pkg::CSR_FRAME_BYTES: begin
               cfg_in.frame_bytes = csr_wdata;
            end
            uvcfa_pkg::CSR_INTERVAL_LOW: begin
               cfg_in.interval_low = csr_wdata[uvcfa_pkg::IVL_W-1:0];
            end
            uvcfa_pkg::CSR_INTERVAL_HIGH: begin
               cfg_in.interval_high = csr_wdata[uvcfa_pkg::IVL_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_bytes   <= uvcfa_pkg::FRAME_BYTES_RESET;
         cfg_ff.interval_low  <= uvcfa_pkg::INTERVAL_LOW_RESET;
         cfg_ff.interval_high <= uvcfa_pkg::INTERVAL_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A byte is taken only when the result buffer will have room for both of
   // the results it might produce.
   assign req_ready = can_load;
   assign accept    = req_valid && can_load;

   uvcfa_deframer #(
      .PACKET_SPAN(PACKET_SPAN)
   ) u_deframer (
      .clock            (clock),
      .reset            (reset),
      .step_en          (accept),
      .data_byte        (req_data_byte),
      .chunk_len        (req_chunk_len),
      .buffer_available (req_buffer_available),
      .time_us          (req_time_us),
      .cfg              (cfg_ff),
      .step             (step)
   );

   uvcfa_result_queue u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .step       (step),
      .can_load   (can_load),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_kind            = result.kind;
   assign rsp_write_offset    = result.write_offset;
   assign rsp_pixel_byte      = result.pixel_byte;
   assign rsp_claimed_buffer  = result.claimed_buffer;
   assign rsp_frame_sequence  = result.frame_sequence;
   assign rsp_frame_time_us   = result.frame_time_us;
   assign rsp_avg_interval_us = result.avg_interval_us;
   assign rsp_last            = result.last;

endmodule

`default_nettype wire

### tb/uvcfa_frame_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the frame assembler. It keeps its own deframer
// model, predicts the results of every accepted byte and compares them with
// what comes out of the response channel.
module uvcfa_frame_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   input  wire logic                             req_ready,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic [uvcfa_pkg::CHUNK_W-1:0]    req_chunk_len,
   input  wire logic                             req_buffer_available,
   input  wire logic [uvcfa_pkg::TIME_W-1:0]     req_time_us,

   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic                             rsp_kind,
   input  wire logic [uvcfa_pkg::FRAME_W-1:0]    rsp_write_offset,
   input  wire logic [7:0]                       rsp_pixel_byte,
   input  wire logic                             rsp_claimed_buffer,
   input  wire logic [uvcfa_pkg::SEQ_W-1:0]      rsp_frame_sequence,
   input  wire logic [uvcfa_pkg::TIME_W-1:0]     rsp_frame_time_us,
   input  wire logic [uvcfa_pkg::IVL_W-1:0]      rsp_avg_interval_us,
   input  wire logic                             rsp_last,

   input  wire logic                             csr_we,
   input  wire logic [uvcfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [uvcfa_pkg::CSR_DATA_W-1:0] csr_wdata,

   output int                                    fault_total,
   output int                                    pending_total,
   output int                                    bytes_total,
   output int                                    writes_total,
   output int                                    frames_total
);

   localparam logic [9:0] SPAN = 10'd512;

   // Register copies.
   logic [uvcfa_pkg::FRAME_W-1:0] frame_size;
   logic [uvcfa_pkg::IVL_W-1:0]   ivl_low;
   logic [uvcfa_pkg::IVL_W-1:0]   ivl_high;

   // Deframer state.
   logic [9:0]                   pkt_pos;
   logic [7:0]                   hdr_len;
   logic                         pkt_skip, pkt_err, pkt_eof, pay_drop;
   logic                         fid_known, fid_cur, in_sync, buf_held, end_valid;
   logic [uvcfa_pkg::FILL_W-1:0] fill;
   logic [uvcfa_pkg::SEQ_W-1:0]  seq_next;
   logic [uvcfa_pkg::TIME_W-1:0] end_time;
   logic [uvcfa_pkg::IVL_W-1:0]  avg_ivl;

   uvcfa_pkg::uvcfa_result_type  byte_results[$];
   uvcfa_pkg::uvcfa_result_type  awaited_results[$];
   uvcfa_pkg::uvcfa_result_type  head;

   int faults = 0;
   int bytes_seen = 0;
   int writes_seen = 0;
   int frames_seen = 0;

   task automatic close_frame(input logic [uvcfa_pkg::TIME_W-1:0] now);
      logic [uvcfa_pkg::TIME_W-1:0] d;
      logic [63:0]                  acc;
      logic                         was_sync;
      logic [uvcfa_pkg::SEQ_W-1:0]  seq;
      uvcfa_pkg::uvcfa_result_type  r;
      was_sync = in_sync;
      if (end_valid) begin
         d = now - end_time;
         if (d >= {20'd0, ivl_low} && d <= {20'd0, ivl_high}) begin
            if (avg_ivl != '0) begin
               acc     = ({44'd0, avg_ivl} * 64'd7 + {24'd0, d}) / 64'd8;
               avg_ivl = acc[uvcfa_pkg::IVL_W-1:0];
            end else begin
               avg_ivl = d[uvcfa_pkg::IVL_W-1:0];
            end
         end
      end
      end_time  = now;
      end_valid = 1'b1;
      in_sync   = 1'b1;
      if (!was_sync && (!buf_held || fill != {1'b0, frame_size})) begin
         // Before the first frame end only a complete frame counts.
         if (buf_held) begin
            fill = '0;
         end
      end else begin
         seq      = seq_next;
         seq_next = seq_next + 32'd1;
         if (buf_held) begin
            if (fill == {1'b0, frame_size}) begin
               r                 = '0;
               r.kind            = uvcfa_pkg::KIND_DELIVER;
               r.frame_sequence  = seq;
               r.frame_time_us   = now;
               r.avg_interval_us = avg_ivl;
               byte_results.push_back(r);
               buf_held = 1'b0;
            end
            fill = '0;
         end
      end
   endtask

   task automatic store_payload(input logic [9:0] pos, input logic [7:0] data,
                                input logic avail);
      logic                        claimed;
      uvcfa_pkg::uvcfa_result_type r;
      claimed = 1'b0;
      if (!pay_drop) begin
         if (!buf_held) begin
            if (pos == {2'b00, hdr_len} && avail) begin
               buf_held = 1'b1;
               fill     = '0;
               claimed  = 1'b1;
            end else begin
               pay_drop = 1'b1;
            end
         end
         if (!pay_drop) begin
            if (fill >= {1'b0, frame_size}) begin
               fill = {1'b0, frame_size} + 25'd1;
            end else begin
               r                = '0;
               r.kind           = uvcfa_pkg::KIND_WRITE;
               r.write_offset   = fill[uvcfa_pkg::FRAME_W-1:0];
               r.pixel_byte     = data;
               r.claimed_buffer = claimed;
               byte_results.push_back(r);
               fill = fill + 25'd1;
            end
         end
      end
   endtask

   task automatic deframe_byte(input logic [7:0] data, input logic [9:0] clen_in,
                               input logic avail,
                               input logic [uvcfa_pkg::TIME_W-1:0] now);
      logic [9:0] clen;
      logic [9:0] pos;
      logic       ends;
      logic       fid;
      clen = (clen_in > SPAN) ? SPAN : clen_in;
      pos  = pkt_pos;
      ends = (pos + 10'd1 >= clen);
      byte_results.delete();
      if (pos == 10'd0) begin
         pkt_skip = 1'b0;
         pkt_err  = 1'b0;
         pkt_eof  = 1'b0;
         pay_drop = 1'b0;
         hdr_len  = data;
         if (data < uvcfa_pkg::MIN_HEADER || {2'b00, data} > clen) begin
            pkt_skip = 1'b1;
         end
      end else if (!pkt_skip) begin
         if (pos == 10'd1) begin
            fid     = data[uvcfa_pkg::INFO_FID_BIT];
            pkt_eof = data[uvcfa_pkg::INFO_EOF_BIT];
            if (fid_known && fid != fid_cur) begin
               close_frame(now);
            end
            fid_cur   = fid;
            fid_known = 1'b1;
            if (data[uvcfa_pkg::INFO_ERR_BIT]) begin
               pkt_err = 1'b1;
               if (buf_held) begin
                  fill = {1'b0, frame_size} + 25'd1;
               end
            end
         end else if (pos >= {2'b00, hdr_len} && !pkt_err) begin
            store_payload(pos, data, avail);
         end
      end
      if (ends) begin
         if (!pkt_skip && pos >= 10'd1 && pkt_eof) begin
            close_frame(now);
            fid_known = 1'b0;
         end
         pkt_pos = '0;
      end else begin
         pkt_pos = pos + 10'd1;
      end
      if (byte_results.size() > 0) begin
         byte_results[byte_results.size() - 1].last = 1'b1;
      end
      foreach (byte_results[i]) begin
         awaited_results.push_back(byte_results[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         faults++;
         if (faults <= 10) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_size = uvcfa_pkg::FRAME_BYTES_RESET;
         ivl_low    = uvcfa_pkg::INTERVAL_LOW_RESET;
         ivl_high   = uvcfa_pkg::INTERVAL_HIGH_RESET;
         pkt_pos    = '0;
         hdr_len    = '0;
         pkt_skip   = 1'b0;
         pkt_err    = 1'b0;
         pkt_eof    = 1'b0;
         pay_drop   = 1'b0;
         fid_known  = 1'b0;
         fid_cur    = 1'b0;
         in_sync    = 1'b0;
         buf_held   = 1'b0;
         end_valid  = 1'b0;
         fill       = '0;
         seq_next   = '0;
         end_time   = '0;
         avg_ivl    = '0;
         awaited_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               uvcfa_pkg::CSR_FRAME_BYTES:   frame_size = csr_wdata;
               uvcfa_pkg::CSR_INTERVAL_LOW:  ivl_low    = csr_wdata[uvcfa_pkg::IVL_W-1:0];
               uvcfa_pkg::CSR_INTERVAL_HIGH: ivl_high   = csr_wdata[uvcfa_pkg::IVL_W-1:0];
               default: ;
            endcase
         end
         // Requests first, so a result that leaves in the same cycle finds
         // its expectation already queued.
         if (req_valid && req_ready) begin
            deframe_byte(req_data_byte, req_chunk_len, req_buffer_available, req_time_us);
            bytes_seen++;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               faults++;
               if (faults <= 10) begin
                  $display("%0t: unexpected result, kind %0d offset %0h seq %0h",
                           $time, rsp_kind, rsp_write_offset, rsp_frame_sequence);
               end
            end else begin
               head = awaited_results.pop_front();
               check_field("kind", 64'(head.kind), 64'(rsp_kind));
               check_field("write_offset", 64'(head.write_offset), 64'(rsp_write_offset));
               check_field("pixel_byte", 64'(head.pixel_byte), 64'(rsp_pixel_byte));
               check_field("claimed_buffer", 64'(head.claimed_buffer),
                           64'(rsp_claimed_buffer));
               check_field("frame_sequence", 64'(head.frame_sequence),
                           64'(rsp_frame_sequence));
               check_field("frame_time_us", 64'(head.frame_time_us),
                           64'(rsp_frame_time_us));
               check_field("avg_interval_us", 64'(head.avg_interval_us),
                           64'(rsp_avg_interval_us));
               check_field("last", 64'(head.last), 64'(rsp_last));
            end
            if (rsp_kind == uvcfa_pkg::KIND_DELIVER) begin
               frames_seen++;
            end else begin
               writes_seen++;
            end
         end
      end
      fault_total   <= faults;
      pending_total <= awaited_results.size();
      bytes_total   <= bytes_seen;
      writes_total  <= writes_seen;
      frames_total  <= frames_seen;
   end

endmodule

### tb/tb_uvc_payload_frame_assembler.sv
`timescale 1ns / 1ps

// Top level of the frame assembler bench. This module only creates stimulus
// and gives the verdict; the checker beside the block does all prediction.
module tb_uvc_payload_frame_assembler;

   logic                             clock;
   logic                             reset;

   logic                             req_valid;
   logic                             req_ready;
   logic [7:0]                       req_data_byte;
   logic [uvcfa_pkg::CHUNK_W-1:0]    req_chunk_len;
   logic                             req_buffer_available;
   logic [uvcfa_pkg::TIME_W-1:0]     req_time_us;

   logic                             rsp_valid;
   logic                             rsp_ready;
   logic                             rsp_kind;
   logic [uvcfa_pkg::FRAME_W-1:0]    rsp_write_offset;
   logic [7:0]                       rsp_pixel_byte;
   logic                             rsp_claimed_buffer;
   logic [uvcfa_pkg::SEQ_W-1:0]      rsp_frame_sequence;
   logic [uvcfa_pkg::TIME_W-1:0]     rsp_frame_time_us;
   logic [uvcfa_pkg::IVL_W-1:0]      rsp_avg_interval_us;
   logic                             rsp_last;

   logic                             csr_we;
   logic [uvcfa_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [uvcfa_pkg::CSR_DATA_W-1:0] csr_wdata;

   int fault_total, pending_total, bytes_total, writes_total, frames_total;

   // Stimulus state. The time stamp only matters where a frame closes, so it
   // advances per packet; frame_fid is the FID of the frame being sent.
   logic [uvcfa_pkg::TIME_W-1:0] now_us = '0;
   logic                         frame_fid = 1'b0;
   bit                           send_idle = 1'b1;
   bit                           recv_idle = 1'b1;
   int                           sent_items = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   uvc_payload_frame_assembler dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_chunk_len        (req_chunk_len),
      .req_buffer_available (req_buffer_available),
      .req_time_us          (req_time_us),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_write_offset     (rsp_write_offset),
      .rsp_pixel_byte       (rsp_pixel_byte),
      .rsp_claimed_buffer   (rsp_claimed_buffer),
      .rsp_frame_sequence   (rsp_frame_sequence),
      .rsp_frame_time_us    (rsp_frame_time_us),
      .rsp_avg_interval_us  (rsp_avg_interval_us),
      .rsp_last             (rsp_last),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   uvcfa_frame_checker checker_i (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_chunk_len        (req_chunk_len),
      .req_buffer_available (req_buffer_available),
      .req_time_us          (req_time_us),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_write_offset     (rsp_write_offset),
      .rsp_pixel_byte       (rsp_pixel_byte),
      .rsp_claimed_buffer   (rsp_claimed_buffer),
      .rsp_frame_sequence   (rsp_frame_sequence),
      .rsp_frame_time_us    (rsp_frame_time_us),
      .rsp_avg_interval_us  (rsp_avg_interval_us),
      .rsp_last             (rsp_last),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .fault_total          (fault_total),
      .pending_total        (pending_total),
      .bytes_total          (bytes_total),
      .writes_total         (writes_total),
      .frames_total         (frames_total)
   );

   // A hung handshake or a lost result ends up here.
   initial begin
      #(10_000_000);
      $display("tb_uvc_payload_frame_assembler: done, errors");
      $finish;
   end

   // Result side. Each transfer is preceded by a random wait when idling is
   // on. Twice the receiver holds off for a long stretch so the two-entry
   // result buffer fills and the block has to stall its request side.
   initial begin
      int gap;
      int taken;
      taken = 0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         gap = recv_idle ? $urandom_range(0, 17) : 0;
         if (taken == 100 || taken == 600) begin
            gap = gap + 400;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Offers one byte and returns at the edge where the transfer happens. With
   // no gap valid simply stays high for the next byte.
   task automatic put_byte(input logic [7:0] data,
                           input logic [uvcfa_pkg::CHUNK_W-1:0] clen,
                           input logic avail);
      int gap;
      gap = send_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_data_byte        <= data;
      req_chunk_len        <= clen;
      req_buffer_available <= avail;
      req_time_us          <= now_us;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   // One packet of n bytes, all carrying chunk length n. A zero length still
   // sends the single byte that the block sees as the whole packet.
   task automatic send_packet(input logic [7:0] hlen, input logic [7:0] info, input int n);
      int         i;
      logic [7:0] b;
      for (i = 0; i < ((n < 1) ? 1 : n); i++) begin
         if (i == 0) begin
            b = hlen;
         end else if (i == 1) begin
            b = info;
         end else begin
            b = 8'($urandom);
         end
         put_byte(b, uvcfa_pkg::CHUNK_W'(n), $urandom_range(0, 9) != 0);
      end
   endtask

   // Random info byte with FID, EOF and ERR forced to the given values.
   function automatic logic [7:0] info_byte(input logic fid, input logic eof,
                                            input logic err);
      logic [7:0] v;
      v                          = 8'($urandom);
      v[uvcfa_pkg::INFO_FID_BIT] = fid;
      v[uvcfa_pkg::INFO_EOF_BIT] = eof;
      v[uvcfa_pkg::INFO_ERR_BIT] = err;
      return v;
   endfunction

   // A well-formed frame: a new FID, payload split over packets of random
   // size (sometimes header only), EOF on the last packet if asked.
   task automatic send_frame(input int size, input logic with_eof, input int step);
      int         left;
      int         chunk;
      logic [7:0] hlen;
      frame_fid = ~frame_fid;
      left      = size;
      do begin
         chunk = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
         if (chunk > left) begin
            chunk = left;
         end
         left = left - chunk;
         hlen = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(2, 14)) : 8'd2;
         send_packet(hlen, info_byte(frame_fid, with_eof && left == 0, 1'b0),
                     int'(hlen) + chunk);
         now_us = now_us + uvcfa_pkg::TIME_W'($urandom_range(0, step));
      end while (left > 0);
   endtask

   // A packet whose chunk length starts above the packet span and is cut
   // short by a smaller length on its final byte.
   task automatic send_shrinking_packet();
      int         i;
      int         m;
      logic [7:0] b;
      logic [9:0] clen;
      m = $urandom_range(3, 9);
      for (i = 0; i < m; i++) begin
         if (i == 0) begin
            b = 8'd2;
         end else if (i == 1) begin
            b = info_byte(frame_fid, 1'($urandom_range(0, 1)), 1'b0);
         end else begin
            b = 8'($urandom);
         end
         clen = (i == m - 1) ? 10'($urandom_range(0, i + 1)) : 10'($urandom_range(513, 1023));
         put_byte(b, clen, $urandom_range(0, 9) != 0);
      end
   endtask

   // One full-span packet. Its chunk length is the field maximum, so only
   // the span clamp ends it.
   task automatic send_full_span_packet();
      int         i;
      logic [7:0] b;
      frame_fid = ~frame_fid;
      for (i = 0; i < 512; i++) begin
         if (i == 0) begin
            b = 8'd2;
         end else if (i == 1) begin
            b = info_byte(frame_fid, 1'b0, 1'b0);
         end else begin
            b = 8'($urandom);
         end
         put_byte(b, 10'h3FF, 1'b1);
      end
   endtask

   task automatic set_config(input logic [uvcfa_pkg::FRAME_W-1:0] size,
                             input logic [uvcfa_pkg::IVL_W-1:0] lo,
                             input logic [uvcfa_pkg::IVL_W-1:0] hi);
      csr_we    <= 1'b1;
      csr_index <= uvcfa_pkg::CSR_FRAME_BYTES;
      csr_wdata <= size;
      @(posedge clock);
      csr_index <= uvcfa_pkg::CSR_INTERVAL_LOW;
      csr_wdata <= {4'd0, lo};
      @(posedge clock);
      csr_index <= uvcfa_pkg::CSR_INTERVAL_HIGH;
      csr_wdata <= {4'd0, hi};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Drop valid, wait for every predicted result, then give the block a few
   // more cycles in case the last bytes produced nothing.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_total != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // Random traffic, mostly whole frames of the expected size. The rest is
   // error packets, skipped packets, stray bytes, packets that change their
   // chunk length, and jumps of the clock across the whole time range.
   task automatic run_phase(input int frame_len, input int step, input int quota);
      int         start;
      int         pick;
      int         n;
      int         i;
      start = sent_items;
      while (sent_items - start < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 66) begin
            n = ($urandom_range(0, 3) != 0) ? frame_len : $urandom_range(0, frame_len + 2);
            send_frame(n, 1'($urandom_range(0, 1)), step);
         end else if (pick < 76) begin
            send_packet(8'd2, info_byte(frame_fid, 1'($urandom_range(0, 1)), 1'b1),
                        $urandom_range(2, 6));
         end else if (pick < 86) begin
            n = $urandom_range(2, 6);
            case ($urandom_range(0, 3))
               0: send_packet(8'($urandom_range(0, 1)), 8'($urandom), n);
               1: send_packet(8'(n + $urandom_range(1, 8)), 8'($urandom), n);
               2: send_packet(8'($urandom), 8'($urandom), 0);
               default: send_packet(8'($urandom), 8'($urandom), 1);
            endcase
         end else if (pick < 92) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
               put_byte(8'($urandom), 10'($urandom_range(0, 1023)),
                        1'($urandom_range(0, 1)));
            end
         end else if (pick < 97) begin
            send_shrinking_packet();
         end else begin
            now_us = {8'($urandom), $urandom};
         end
      end
   endtask

   task automatic phase(input logic [uvcfa_pkg::FRAME_W-1:0] size,
                        input logic [uvcfa_pkg::IVL_W-1:0] lo,
                        input logic [uvcfa_pkg::IVL_W-1:0] hi, input int frame_len,
                        input int step, input int quota, input bit s_idle,
                        input bit r_idle);
      send_idle = s_idle;
      recv_idle = r_idle;
      set_config(size, lo, hi);
      run_phase(frame_len, step, quota);
      settle();
   endtask

   initial begin
      int fsize;
      int lo;
      req_valid            <= 1'b0;
      req_data_byte        <= '0;
      req_chunk_len        <= '0;
      req_buffer_available <= 1'b0;
      req_time_us          <= '0;
      csr_we               <= 1'b0;
      csr_index            <= uvcfa_pkg::CSR_FRAME_BYTES;
      csr_wdata            <= '0;
      reset                <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part with three-byte frames and an open interval window.
      set_config(24'd3, 20'd0, 20'hFFFFF);

      // First frame, FID 0, time close to the top of the range.
      now_us = 40'hFF_FFFF_FF00;
      put_byte(8'd2, 10'd5, 1'b1);
      put_byte(info_byte(1'b0, 1'b0, 1'b0), 10'd5, 1'b1);
      put_byte(8'h00, 10'd5, 1'b1);
      put_byte(8'hFF, 10'd5, 1'b1);
      put_byte(8'hA5, 10'd5, 1'b1);

      // FID toggles with EOF set: the toggle delivers the first frame, and
      // the last byte gives both a write and a second delivery.
      now_us = 40'hFF_FFFF_FFFF;
      put_byte(8'd2, 10'd5, 1'b1);
      put_byte(info_byte(1'b1, 1'b1, 1'b0), 10'd5, 1'b1);
      put_byte(8'h5A, 10'd5, 1'b1);
      put_byte(8'hFF, 10'd5, 1'b1);
      put_byte(8'h00, 10'd5, 1'b1);

      // The clock wraps; an errored packet's payload is ignored.
      now_us = 40'h00_0000_0010;
      put_byte(8'd2, 10'd4, 1'b1);
      put_byte(info_byte(1'b1, 1'b0, 1'b1), 10'd4, 1'b1);
      put_byte(8'h11, 10'd4, 1'b1);
      put_byte(8'h22, 10'd4, 1'b1);

      // Header shorter than the minimum, then one longer than its packet.
      put_byte(8'd1, 10'd2, 1'b1);
      put_byte(8'h03, 10'd2, 1'b1);
      put_byte(8'd9, 10'd3, 1'b1);
      put_byte(8'h01, 10'd3, 1'b1);
      put_byte(8'h77, 10'd3, 1'b1);

      // Chunk lengths of zero and one.
      put_byte(8'h00, 10'd0, 1'b1);
      put_byte(8'hFF, 10'd1, 1'b1);

      // FID toggles back with no buffer queued, so the payload is dropped.
      now_us = 40'h00_0000_4000;
      put_byte(8'd2, 10'd3, 1'b1);
      put_byte(info_byte(1'b0, 1'b0, 1'b0), 10'd3, 1'b1);
      put_byte(8'h33, 10'd3, 1'b0);
      frame_fid = 1'b0;
      settle();

      // Random phases, each with its own register setting and an idling mix.
      phase(24'd5, 20'd100, 20'd4000, 5, 1500, 160, 1'b1, 1'b1);
      phase(24'd1, 20'd0, 20'hFFFFF, 1, 300000, 130, 1'b0, 1'b1);
      phase(24'd0, 20'd0, 20'd0, 2, 3, 80, 1'b1, 1'b0);
      fsize = $urandom_range(2, 24);
      lo    = $urandom_range(0, 3000);
      phase(uvcfa_pkg::FRAME_W'(fsize), uvcfa_pkg::IVL_W'(lo),
            uvcfa_pkg::IVL_W'(lo + $urandom_range(0, 6000)),
            fsize, 2500, 160, 1'b1, 1'b1);
      phase(24'd7, 20'hFFFFF, 20'd0, 7, 1000, 80, 1'b0, 1'b0);

      // Largest frame size: nothing completes, and one packet runs the full
      // packet span.
      send_idle = 1'b1;
      recv_idle = 1'b1;
      set_config(24'hFFFFFF, 20'd16666, 20'd200000);
      send_full_span_packet();
      run_phase(10, 60000, 40);
      settle();

      phase(24'd3, 20'd16666, 20'd200000, 3, 50000, 100, 1'b1, 1'b1);

      $display("Covered %0d input bytes giving %0d payload writes and %0d frame deliveries,",
               bytes_total, writes_total, frames_total);
      $display("across eight register settings with a full-span packet and receiver stalls.");
      if (fault_total == 0) begin
         $display("tb_uvc_payload_frame_assembler: done, clean");
      end else begin
         $display("tb_uvc_payload_frame_assembler: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
sv/uvcfa_pkg.sv
sv/uvcfa_deframer.sv
sv/uvcfa_result_queue.sv
sv/uvc_payload_frame_assembler.sv
tb/uvcfa_frame_checker.sv
tb/tb_uvc_payload_frame_assembler.sv
